/* design/lprc_pkg.sv */
// Package: shared types, constants and the CRC-32 byte update for the record checker.
`timescale 1ns / 1ps

package lprc_pkg;

    // Bit of the length word that flags a trailing CRC
    localparam int FLAG_BIT       = 31;
    // Width of the byte position and record start counters
    localparam int POSITION_WIDTH = 32;
    // Compare width: wide enough that start + 4 + length + 4 never wraps
    localparam int CMP_W = ((POSITION_WIDTH > 32) ? POSITION_WIDTH : 32) + 2;

    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] FLAG_MASK = 32'h1 << FLAG_BIT;

    // Result status codes
    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;
    localparam logic [1:0] ST_END     = 2'd3;

    typedef logic [POSITION_WIDTH-1:0] pos_t;

    // One queued input transfer
    typedef struct packed {
        logic       restart;
        logic [7:0] data;
    } lprc_entry_t;

    // One result item
    typedef struct packed {
        logic [30:0] payload_length;
        logic [31:0] record_start;
        logic [1:0]  status;
        logic        record_done;
        logic        byte_valid;
        logic [7:0]  payload_byte;
    } lprc_result_t;

    // Reflected CRC-32 update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* design/lprc_front.sv */
// Front end: accepts input transfers, tags restarts and queues them for the checker.
`timescale 1ns / 1ps

module lprc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic [0:0]            s_tuser,
    output logic                  q_valid,
    output lprc_pkg::lprc_entry_t q_head,
    input  logic                  q_pop
);

    lprc_pkg::lprc_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_head   = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified transfer
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg].restart <= s_tuser[0];
            slot_reg[wr_ptr_reg].data    <= s_tdata;
        end
    end

endmodule

/* design/lprc_back.sv */
// Back end: record parser, CRC check and the output register.
`timescale 1ns / 1ps

module lprc_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [31:0]            cfg_data,
    input  logic                   q_valid,
    input  lprc_pkg::lprc_entry_t  q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    output lprc_pkg::lprc_result_t out_data,
    input  logic                   out_ready
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CRC     = 2'd2;

    logic [31:0]          limit_reg;
    logic [1:0]           phase_reg, phase_next;
    logic                 halted_reg, halted_next;
    logic [1:0]           fbc_reg, fbc_next;
    logic [31:0]          lw_reg, lw_next;
    logic                 has_crc_reg, has_crc_next;
    logic [30:0]          left_reg, left_next;
    logic [31:0]          crc_reg, crc_next;
    logic [31:0]          exp_reg, exp_next;
    lprc_pkg::pos_t       pos_reg, pos_next;
    lprc_pkg::pos_t       start_reg, start_next;

    logic                 out_valid_reg;
    lprc_pkg::lprc_result_t out_reg;

    logic                 emit;
    logic                 emit_bv;
    logic                 emit_done;
    logic [1:0]           emit_st;
    logic [31:0]          lw_base;
    logic [31:0]          len_full;
    logic [lprc_pkg::CMP_W-1:0] start_ext;
    logic [lprc_pkg::CMP_W-1:0] lim_ext;
    logic [lprc_pkg::CMP_W-1:0] need;
    logic                 at_end;
    logic                 overrun;

    assign cfg_ready = 1'b1;
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign start_ext = lprc_pkg::CMP_W'(start_reg);
    assign lim_ext   = lprc_pkg::CMP_W'(limit_reg);
    assign at_end    = (start_ext + lprc_pkg::CMP_W'(4)) > lim_ext;
    assign lw_base   = (fbc_reg == 2'd0) ? 32'd0 : lw_reg;
    assign len_full  = lw_next & ~lprc_pkg::FLAG_MASK;
    assign need      = lprc_pkg::CMP_W'(len_full) + lprc_pkg::CMP_W'(4)
                     + (lw_next[lprc_pkg::FLAG_BIT] ? lprc_pkg::CMP_W'(4) : lprc_pkg::CMP_W'(0));
    assign overrun   = len_full[31] || ((start_ext + need) > lim_ext);

    // Step the record parser on the popped transfer
    always_comb begin
        phase_next   = phase_reg;
        halted_next  = halted_reg;
        fbc_next     = fbc_reg;
        lw_next      = lw_reg;
        has_crc_next = has_crc_reg;
        left_next    = left_reg;
        crc_next     = crc_reg;
        exp_next     = exp_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        emit         = 1'b0;
        emit_bv      = 1'b0;
        emit_done    = 1'b0;
        emit_st      = lprc_pkg::ST_GOOD;
        if (q_pop) begin
            if (q_head.restart) begin
                phase_next   = PH_HEADER;
                halted_next  = 1'b0;
                fbc_next     = 2'd0;
                lw_next      = 32'd0;
                has_crc_next = 1'b0;
                left_next    = 31'd0;
                crc_next     = lprc_pkg::CRC_INIT;
                exp_next     = 32'd0;
                pos_next     = '0;
                start_next   = '0;
            end else if (!halted_reg) begin
                case (phase_reg)
                    PH_PAYLOAD: begin
                        crc_next  = lprc_pkg::crc_byte(crc_reg, q_head.data);
                        pos_next  = pos_reg + lprc_pkg::pos_t'(1);
                        left_next = left_reg - 31'd1;
                        emit      = 1'b1;
                        emit_bv   = 1'b1;
                        if (left_next == 31'd0) begin
                            if (has_crc_reg) begin
                                phase_next = PH_CRC;
                                fbc_next   = 2'd0;
                                exp_next   = 32'd0;
                            end else begin
                                emit_done  = 1'b1;
                                phase_next = PH_HEADER;
                                fbc_next   = 2'd0;
                                start_next = pos_next;
                            end
                        end
                    end
                    PH_CRC: begin
                        exp_next = {exp_reg[23:0], q_head.data};
                        pos_next = pos_reg + lprc_pkg::pos_t'(1);
                        fbc_next = fbc_reg + 2'd1;
                        if (fbc_next == 2'd0) begin
                            emit      = 1'b1;
                            emit_done = 1'b1;
                            if ((crc_reg ^ lprc_pkg::CRC_INIT) == exp_next) begin
                                phase_next = PH_HEADER;
                                start_next = pos_next;
                            end else begin
                                emit_st     = lprc_pkg::ST_CRC_ERR;
                                halted_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                        if (fbc_reg == 2'd0 && at_end) begin
                            lw_next     = 32'd0;
                            emit        = 1'b1;
                            emit_done   = 1'b1;
                            emit_st     = lprc_pkg::ST_END;
                            halted_next = 1'b1;
                        end else begin
                            lw_next  = {lw_base[23:0], q_head.data};
                            pos_next = pos_reg + lprc_pkg::pos_t'(1);
                            fbc_next = fbc_reg + 2'd1;
                            if (fbc_next == 2'd0) begin
                                has_crc_next = lw_next[lprc_pkg::FLAG_BIT];
                                if (overrun) begin
                                    emit        = 1'b1;
                                    emit_done   = 1'b1;
                                    emit_st     = lprc_pkg::ST_OVERRUN;
                                    halted_next = 1'b1;
                                end else begin
                                    crc_next  = lprc_pkg::CRC_INIT;
                                    left_next = len_full[30:0];
                                    if (len_full != 32'd0) begin
                                        phase_next = PH_PAYLOAD;
                                    end else if (lw_next[lprc_pkg::FLAG_BIT]) begin
                                        phase_next = PH_CRC;
                                        fbc_next   = 2'd0;
                                        exp_next   = 32'd0;
                                    end else begin
                                        emit       = 1'b1;
                                        emit_done  = 1'b1;
                                        start_next = pos_next;
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Hold the region limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            halted_reg  <= 1'b0;
            fbc_reg     <= 2'd0;
            lw_reg      <= 32'd0;
            has_crc_reg <= 1'b0;
            left_reg    <= 31'd0;
            crc_reg     <= lprc_pkg::CRC_INIT;
            exp_reg     <= 32'd0;
            pos_reg     <= '0;
            start_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            halted_reg  <= halted_next;
            fbc_reg     <= fbc_next;
            lw_reg      <= lw_next;
            has_crc_reg <= has_crc_next;
            left_reg    <= left_next;
            crc_reg     <= crc_next;
            exp_reg     <= exp_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
        end
    end

    // Output register: load a new result, drop it once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg.payload_byte   <= emit_bv ? q_head.data : 8'd0;
            out_reg.byte_valid     <= emit_bv;
            out_reg.record_done    <= emit_done;
            out_reg.status         <= emit_st;
            out_reg.record_start   <= start_ext[31:0];
            out_reg.payload_length <= len_full[30:0];
        end
    end

    // A result is only produced from a transfer taken off the queue
    a_emit_from_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> q_pop)
        else $error("result produced without a queued transfer");

    // Entering the halted state always reports a final result whose status is not good
    a_halt_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !halted_reg && halted_next) |=>
            (out_valid_reg && out_reg.record_done && out_reg.status != lprc_pkg::ST_GOOD))
        else $error("halt without a final error result");

    // A result that is not final always carries a payload byte
    a_mid_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.record_done) |-> out_reg.byte_valid)
        else $error("non-final result without payload byte");

    // Error status only on a final result
    a_mid_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.record_done) |-> (out_reg.status == lprc_pkg::ST_GOOD))
        else $error("error status on a non-final result");

    // A halted checker stays quiet until a restart
    a_halted_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && q_pop && !q_head.restart) |-> !emit)
        else $error("result while halted");

endmodule

/* design/length_prefixed_record_checker_unit.sv */
// Top level: length-prefixed record checker with CRC-32 over the payload.
`timescale 1ns / 1ps

// Scans a byte stream of length-prefixed records from position zero up to the
// configured region limit. Each record opens with a 4-byte big-endian length
// word; its top bit flags a trailing 4-byte big-endian CRC-32 of the payload.
// Payload bytes come out as they arrive, and each record ends with one result
// with tlast set and a final status (good, CRC mismatch, overrun, end of
// region). After an error or end of region the checker halts until a restart
// transfer (tuser bit 0 set). The block takes one byte per clock cycle while the
// result stream is not stalled; the rate is set by the bytewise CRC update,
// which is combinational. Input bytes wait in a two-entry queue ahead of the
// parser; a popped byte is parsed and its result is registered in the output
// register, from which it is presented on the result stream.
// Header and CRC bytes, other than the one that ends a record, give no result.
// Write the region limit only while the block is idle.
module length_prefixed_record_checker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Region limit register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] action (1 = restart)
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] payload_byte, [39:8] record_start,
                                   // [70:40] payload_length, [71] zero
    output logic [2:0]  m_tuser,   // [0] byte_valid, [2:1] status
    output logic        m_tlast    // record_done
);

    logic                   q_valid;
    lprc_pkg::lprc_entry_t  q_head;
    logic                   q_pop;
    lprc_pkg::lprc_result_t res;

    lprc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    lprc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_data  (res),
        .out_ready (m_tready)
    );

    // Pack the result fields onto the stream
    assign m_tdata = {1'b0, res.payload_length, res.record_start, res.payload_byte};
    assign m_tuser = {res.status, res.byte_valid};
    assign m_tlast = res.record_done;

endmodule

/* dv/testbench.sv */
// Testbench: random and directed record streams checked against a cycle-free scan predictor.
`timescale 1ns / 1ps

module testbench;

    typedef enum logic [1:0] {
        SCAN_HEADER  = 2'd0,
        SCAN_PAYLOAD = 2'd1,
        SCAN_CRC     = 2'd2
    } scan_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] data_byte
    logic [0:0]  s_tuser = '0;    // [0] action (1 = restart)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // [7:0] payload_byte, [39:8] record_start,
                                  // [70:40] payload_length
    logic [2:0]  m_tuser;         // [0] byte_valid, [2:1] status
    logic        m_tlast;         // record_done

    length_prefixed_record_checker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Byte stream waiting to be driven, and results the scan predictor expects
    lprc_pkg::lprc_entry_t  stream_queue[$];
    lprc_pkg::lprc_result_t predicted_results[$];

    // Predictor copy of the region register and the scan state
    logic [31:0]    region_lim = '0;
    scan_phase_t    scan_ph;
    logic           scan_halted;
    logic [1:0]     field_cnt;
    logic [31:0]    len_word;
    logic           with_crc;
    logic [30:0]    bytes_left;
    logic [31:0]    crc_run;
    logic [31:0]    crc_seen;
    lprc_pkg::pos_t scan_pos;
    lprc_pkg::pos_t rec_start;

    // Idle odds per side (out of 4) and bookkeeping
    int unsigned gap_odds = 0;
    int unsigned stall_odds = 0;
    int unsigned items_built = 0;
    int unsigned transfers_in = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned limit_writes = 0;
    int unsigned outcome_cnt[4] = '{0, 0, 0, 0};

    // Reflected CRC-32, one input bit at a time
    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ lprc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_scan();
        scan_ph     = SCAN_HEADER;
        scan_halted = 1'b0;
        field_cnt   = '0;
        len_word    = '0;
        with_crc    = 1'b0;
        bytes_left  = '0;
        crc_run     = lprc_pkg::CRC_INIT;
        crc_seen    = '0;
        scan_pos    = '0;
        rec_start   = '0;
    endfunction

    function automatic void open_record();
        scan_ph   = SCAN_HEADER;
        field_cnt = '0;
        rec_start = scan_pos;
    endfunction

    function automatic void post_result(input logic [7:0] pb, input logic bv, input logic done,
                                        input logic [1:0] st);
        lprc_pkg::lprc_result_t r;
        logic [31:0]            body_len;
        body_len         = len_word & ~lprc_pkg::FLAG_MASK;
        r.payload_byte   = pb;
        r.byte_valid     = bv;
        r.record_done    = done;
        r.status         = st;
        r.record_start   = 32'(rec_start);
        r.payload_length = body_len[30:0];
        predicted_results.insert(predicted_results.size(), r);
    endfunction

    // Advance the scan by one accepted transfer and queue any result it causes
    function automatic void scan_transfer(input lprc_pkg::lprc_entry_t it);
        logic [31:0] body_len;
        logic [63:0] need;
        logic [63:0] lim64;
        logic [63:0] start64;
        lim64   = {32'd0, region_lim};
        start64 = 64'(rec_start);
        if (it.restart) begin
            clear_scan();
            return;
        end
        if (scan_halted) begin
            return;
        end
        case (scan_ph)
            SCAN_PAYLOAD: begin
                crc_run    = crc32_update(crc_run, it.data);
                scan_pos   = scan_pos + lprc_pkg::pos_t'(1);
                bytes_left = bytes_left - 31'd1;
                if (bytes_left != 0) begin
                    post_result(it.data, 1'b1, 1'b0, lprc_pkg::ST_GOOD);
                end else if (with_crc) begin
                    scan_ph   = SCAN_CRC;
                    field_cnt = '0;
                    crc_seen  = '0;
                    post_result(it.data, 1'b1, 1'b0, lprc_pkg::ST_GOOD);
                end else begin
                    post_result(it.data, 1'b1, 1'b1, lprc_pkg::ST_GOOD);
                    open_record();
                end
            end
            SCAN_CRC: begin
                crc_seen  = {crc_seen[23:0], it.data};
                scan_pos  = scan_pos + lprc_pkg::pos_t'(1);
                field_cnt = field_cnt + 2'd1;
                if (field_cnt == 0) begin
                    if ((crc_run ^ lprc_pkg::CRC_INIT) == crc_seen) begin
                        post_result(8'd0, 1'b0, 1'b1, lprc_pkg::ST_GOOD);
                        open_record();
                    end else begin
                        post_result(8'd0, 1'b0, 1'b1, lprc_pkg::ST_CRC_ERR);
                        scan_halted = 1'b1;
                    end
                end
            end
            default: begin
                scan_ph = SCAN_HEADER;
                if (field_cnt == 0) begin
                    len_word = '0;
                    // Fewer than four bytes left at a record start: byte is not consumed
                    if (lim64 < 64'd4 || start64 > lim64 - 64'd4) begin
                        post_result(8'd0, 1'b0, 1'b1, lprc_pkg::ST_END);
                        scan_halted = 1'b1;
                        return;
                    end
                end
                len_word  = {len_word[23:0], it.data};
                scan_pos  = scan_pos + lprc_pkg::pos_t'(1);
                field_cnt = field_cnt + 2'd1;
                if (field_cnt != 0) begin
                    return;
                end
                body_len = len_word & ~lprc_pkg::FLAG_MASK;
                with_crc = len_word[lprc_pkg::FLAG_BIT];
                need     = 64'd4 + 64'(body_len) + (with_crc ? 64'd4 : 64'd0);
                if (body_len > 32'h7FFF_FFFF || start64 > lim64 || need > lim64 - start64) begin
                    post_result(8'd0, 1'b0, 1'b1, lprc_pkg::ST_OVERRUN);
                    scan_halted = 1'b1;
                    return;
                end
                crc_run    = lprc_pkg::CRC_INIT;
                bytes_left = body_len[30:0];
                if (body_len != 0) begin
                    scan_ph = SCAN_PAYLOAD;
                end else if (with_crc) begin
                    scan_ph   = SCAN_CRC;
                    field_cnt = '0;
                    crc_seen  = '0;
                end else begin
                    post_result(8'd0, 1'b0, 1'b1, lprc_pkg::ST_GOOD);
                    open_record();
                end
            end
        endcase
    endfunction

    // Driver: hold each item until its transfer, then wait a drawn gap
    lprc_pkg::lprc_entry_t cur_item;
    int unsigned           send_gap = 0;
    logic                  holding;

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_scan();
            send_gap = 0;
            s_tvalid <= 1'b0;
        end else begin
            holding = s_tvalid;
            if (s_tvalid && s_tready) begin
                scan_transfer(cur_item);
                transfers_in++;
                holding  = 1'b0;
                send_gap = ($urandom_range(0, 3) < gap_odds) ? $urandom_range(0, 15) : 0;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (stream_queue.size() != 0) begin
                    cur_item = stream_queue.pop_front();
                    s_tdata <= cur_item.data;
                    s_tuser <= cur_item.restart;
                    holding  = 1'b1;
                end
            end
            s_tvalid <= holding;
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_checked, name, want, got);
            end
        end
    endfunction

    // Monitor: check each result transfer against the oldest prediction
    int unsigned            stall_left = 0;
    lprc_pkg::lprc_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: tdata 0x%0h tuser 0x%0h tlast %0b",
                                 m_tdata, m_tuser, m_tlast);
                    end
                end else begin
                    want = predicted_results.pop_front();
                    check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[7:0]));
                    check_field("byte_valid", 32'(want.byte_valid), 32'(m_tuser[0]));
                    check_field("record_done", 32'(want.record_done), 32'(m_tlast));
                    check_field("status", 32'(want.status), 32'(m_tuser[2:1]));
                    check_field("record_start", want.record_start, m_tdata[39:8]);
                    check_field("payload_length", 32'(want.payload_length),
                                32'(m_tdata[70:40]));
                end
                if (m_tlast) begin
                    outcome_cnt[m_tuser[2:1]]++;
                end
                results_checked++;
                stall_left = ($urandom_range(0, 3) < stall_odds) ? $urandom_range(0, 15) : 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus building blocks
    task automatic push_item(input logic restart, input logic [7:0] data);
        lprc_pkg::lprc_entry_t it;
        it.restart = restart;
        it.data    = data;
        stream_queue.insert(stream_queue.size(), it);
        items_built++;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            push_item(1'b0, w[31 - 8 * i -: 8]);
        end
    endtask

    // Bytes sent after a halt; the block drops them
    task automatic push_noise();
        lprc_pkg::lprc_entry_t it;
        repeat ($urandom_range(0, 3)) begin
            it.restart = 1'b0;
            it.data    = 8'($urandom);
            stream_queue.insert(stream_queue.size(), it);
        end
    endtask

    task automatic push_record(input bit flag, input int unsigned body, input bit bad);
        logic [31:0] crc;
        logic [7:0]  b;
        push_word(body | (flag ? lprc_pkg::FLAG_MASK : 32'd0));
        crc = lprc_pkg::CRC_INIT;
        for (int unsigned i = 0; i < body; i++) begin
            b   = 8'($urandom);
            crc = crc32_update(crc, b);
            push_item(1'b0, b);
        end
        if (flag) begin
            crc = crc ^ lprc_pkg::CRC_INIT;
            if (bad) begin
                crc[$urandom_range(0, 31)] ^= 1'b1;
            end
            push_word(crc);
        end
    endtask

    // Start of a record cut short by the next restart
    task automatic push_truncated(input bit huge);
        logic [31:0] lw;
        int unsigned cut;
        lw = huge ? 32'h7FFF_FFFF : 32'($urandom_range(0, 40));
        if ($urandom_range(0, 1)) begin
            lw = lw | lprc_pkg::FLAG_MASK;
        end
        cut = $urandom_range(1, 16);
        for (int unsigned i = 0; i < cut; i++) begin
            push_item(1'b0, (i < 4) ? lw[31 - 8 * i -: 8] : 8'($urandom));
        end
    endtask

    // One scan from a restart: mostly well-formed records, ending in an error,
    // the end of the region or a cut-off record
    task automatic build_scan(input logic [31:0] lim);
        longint unsigned gp;
        longint unsigned room;
        longint unsigned maxb;
        int unsigned     recs;
        int unsigned     want_recs;
        int unsigned     kind;
        int unsigned     body;
        bit              flag;
        bit              bad;
        bit              done;
        gp        = 0;
        recs      = 0;
        done      = 1'b0;
        want_recs = $urandom_range(1, 8);
        push_item(1'b1, 8'($urandom));
        while (!done) begin
            room = (gp > lim) ? 0 : lim - gp;
            kind = $urandom_range(0, 99);
            if (room < 4) begin
                push_item(1'b0, 8'($urandom));
                push_noise();
                done = 1'b1;
            end else if (kind < 5 || (room > 64'd1_000_000 && recs >= want_recs)) begin
                push_truncated(room > 64'd1_000_000 && $urandom_range(0, 1));
                done = 1'b1;
            end else if (kind < 10 && room < 64'h8000_0000) begin
                flag = 1'($urandom_range(0, 1));
                body = 32'(room - 4) + $urandom_range(1, 3);
                push_word(body | (flag ? lprc_pkg::FLAG_MASK : 32'd0));
                push_noise();
                done = 1'b1;
            end else begin
                flag = (room >= 8) ? 1'($urandom_range(0, 1)) : 1'b0;
                maxb = room - 4 - (flag ? 4 : 0);
                if (maxb > (($urandom_range(0, 7) == 0) ? 64 : 12)) begin
                    maxb = ($urandom_range(0, 7) == 0) ? 64 : 12;
                end
                body = ($urandom_range(0, 3) == 0) ? 32'(maxb) : $urandom_range(0, 32'(maxb));
                bad  = flag && kind < 16;
                push_record(flag, body, bad);
                gp += 4 + body + (flag ? 4 : 0);
                recs++;
                if (bad) begin
                    push_noise();
                    done = 1'b1;
                end
            end
        end
    endtask

    // Wait until every item is sent and every result is in, then let the pipe settle
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (stream_queue.size() != 0 || s_tvalid || predicted_results.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [31:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        region_lim = v;
        limit_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Run limit
    initial begin
        #4_000_000;
        $display("** length_prefixed_record_checker_unit: FAILED **");
        $finish;
    end

    logic [31:0] lim;

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty region: every record start hits the end; halted bytes are dropped
        set_limit(32'd0);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'hA5);
        push_item(1'b1, 8'h00);
        push_item(1'b0, 8'hFF);
        drain();

        // Full region: empty record, bad CRC on an empty payload, longest length
        set_limit(32'hFFFF_FFFF);
        push_word(32'h0000_0000);
        push_word(lprc_pkg::FLAG_MASK);
        push_word(32'h0000_0001);
        push_item(1'b1, 8'hFF);
        push_word(32'h7FFF_FFFF);
        push_item(1'b0, 8'h5A);
        push_item(1'b1, 8'h00);
        drain();

        // Small region: longest length with CRC overruns
        set_limit(32'd20);
        push_word(32'hFFFF_FFFF);
        drain();

        // Random phases, each with its own region limit and idle pattern
        items_built = 0;
        while (items_built < 1250) begin
            case ($urandom_range(0, 9))
                0: lim = $urandom_range(0, 7);
                1: lim = 32'hFFFF_FFFF;
                2: lim = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                default: lim = $urandom_range(8, 160);
            endcase
            set_limit(lim);
            gap_odds   = $urandom_range(0, 3);
            stall_odds = $urandom_range(0, 3);
            repeat ($urandom_range(1, 4)) build_scan(lim);
            drain();
        end

        $display("%0d input transfers, %0d results checked, %0d region limit writes",
                 transfers_in, results_checked, limit_writes);
        $display("outcomes: %0d good, %0d crc mismatch, %0d overrun, %0d end of region",
                 outcome_cnt[0], outcome_cnt[1], outcome_cnt[2], outcome_cnt[3]);
        if (mismatches == 0) begin
            $display("** length_prefixed_record_checker_unit: PASSED **");
        end else begin
            $display("** length_prefixed_record_checker_unit: FAILED **");
        end
        $finish;
    end

endmodule
